>>> rtl/core/tilt_complementary_filter_unit_defines.svh
// Assertion macros shared by the tilt filter RTL.
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define TCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/tcf_pkg.sv
// Package with constants and tables of the tilt complementary filter.
package tcf_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GYRO_WIDTH_DEF   = 16;
  localparam int ACCEL_WIDTH_DEF  = 10;
  localparam int CORDIC_MAX       = 24;
  localparam int STATE_W          = 25;
  localparam int OUT_W            = 16;
  localparam int TRUST_W          = 16;
  localparam int DB_W             = 8;
  localparam int GAIN_W           = 16;
  localparam int ANG_W            = 23;

  localparam logic [TRUST_W-1:0] TRUST_RST = 16'd31130;
  localparam logic [DB_W-1:0]    DB_RST    = 8'd3;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd7295;

  localparam logic [1:0] REG_TRUST = 2'd0;
  localparam logic [1:0] REG_DB    = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;

  function automatic logic [ANG_W-1:0] atan_q8(input logic [4:0] i);
    logic [ANG_W-1:0] r;
    unique case (i)
      5'd0: r = 23'd1152000;  5'd1: r = 23'd680065;  5'd2: r = 23'd359328;
      5'd3: r = 23'd182400;   5'd4: r = 23'd91554;   5'd5: r = 23'd45822;
      5'd6: r = 23'd22916;    5'd7: r = 23'd11459;   5'd8: r = 23'd5730;
      5'd9: r = 23'd2865;     5'd10: r = 23'd1432;   5'd11: r = 23'd716;
      5'd12: r = 23'd358;     5'd13: r = 23'd179;    5'd14: r = 23'd90;
      5'd15: r = 23'd45;      5'd16: r = 23'd22;     5'd17: r = 23'd11;
      5'd18: r = 23'd6;       5'd19: r = 23'd3;      5'd20: r = 23'd1;
      5'd21: r = 23'd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

>>> rtl/core/tilt_complementary_filter_unit.sv
// Top level of the tilt complementary filter with its sequencer and datapath.
// Usage: one item on the in_ channel carries a gyro sample and an
// accelerometer sample of all three axes. The block answers each item with
// one item on the out_ channel holding roll, pitch and yaw in hundredths of
// a degree, saturated to 16 bits. Three angle estimates persist between
// items.
// Timing: the block handles one item at a time. The gyro steps are formed
// by a shift-add multiplier that takes one gain bit a cycle, and the
// accelerometer tilts by a CORDIC that runs one iteration a cycle for roll
// and pitch in parallel. The two blends also use one trust bit a cycle.
// CORDIC steps are capped at 24. The next item is accepted only after
// the result has moved into the output register; the result may wait
// there while the next item is worked on.
// Reset clears the estimates to zero and loads the register defaults.
// When the receiver stalls, the result holds and the next result waits
// finished inside the block until the output register frees.
// Registers are written over the cfg_ APB-style port at 4*index; pready is
// always high and reads return the register value.
module tilt_complementary_filter_unit #(
  parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF,
  parameter int GYRO_WIDTH   = tcf_pkg::GYRO_WIDTH_DEF,
  parameter int ACCEL_WIDTH  = tcf_pkg::ACCEL_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z from the lowest bit,
  // zero-padded to whole bytes.
  input  logic [((3*GYRO_WIDTH+3*ACCEL_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // angle_roll, angle_pitch, angle_yaw from the lowest bit.
  output logic [47:0] out_tdata,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import tcf_pkg::*;
`include "tilt_complementary_filter_unit_defines.svh"

  localparam int STEPS = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
  localparam int GMAG_W = GYRO_WIDTH;            // magnitude up to 2^(w-1)
  localparam int PROD_W = GMAG_W + GAIN_W;
  localparam int STEP_W = PROD_W - 8 + 1;        // signed step
  localparam int AMAG_W = ACCEL_WIDTH;
  localparam int CX_W   = AMAG_W + 8 + 3;        // CORDIC x/y with growth
  localparam int SUM_W  = STATE_W + 2 + (STEP_W > STATE_W ? STEP_W - STATE_W : 0);
  localparam int ACC_W  = SUM_W + TRUST_W + 2;
  localparam int CNT_W  = 5;

  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_COR = 3'd2,
                         S_BLD = 3'd3, S_UPD = 3'd4, S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  // Configuration registers.
  logic [TRUST_W-1:0] trust_r;
  logic [DB_W-1:0]    db_r;
  logic [GAIN_W-1:0]  gain_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trust_r <= TRUST_RST;
      db_r    <= DB_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[3:2] == REG_TRUST) trust_r <= cfg_pwdata[TRUST_W-1:0];
      if (cfg_paddr[3:2] == REG_DB)    db_r    <= cfg_pwdata[DB_W-1:0];
      if (cfg_paddr[3:2] == REG_GAIN)  gain_r  <= cfg_pwdata[GAIN_W-1:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[3:2])
        REG_TRUST: cfg_prdata = {{(32-TRUST_W){1'b0}}, trust_r};
        REG_DB:    cfg_prdata = {{(32-DB_W){1'b0}}, db_r};
        REG_GAIN:  cfg_prdata = {{(32-GAIN_W){1'b0}}, gain_r};
        default:   cfg_prdata = '0;
      endcase
    end
  end

  // Input field unpacking.
  logic signed [GYRO_WIDTH-1:0]  gin [3];
  logic signed [ACCEL_WIDTH-1:0] ain [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gin[k] = in_tdata[k*GYRO_WIDTH +: GYRO_WIDTH];
      ain[k] = in_tdata[3*GYRO_WIDTH + k*ACCEL_WIDTH +: ACCEL_WIDTH];
    end
  end

  // Working registers.
  logic [GMAG_W-1:0] gmag_r [3];
  logic [2:0]        gneg_r, gzero_r;
  logic [PROD_W-1:0] prod_r [3];
  logic [GAIN_W-1:0] gsh_r;
  logic signed [CX_W-1:0] cx_r [2];
  logic signed [CX_W-1:0] cy_r [2];
  logic signed [ANG_W+1:0] cang_r [2];
  logic [1:0] aneg_r, azero_r;
  logic signed [STATE_W-1:0] est_r [3];
  logic signed [SUM_W-1:0]  sumg_r [2];   // angle + step
  logic signed [SUM_W-1:0]  tilt_r [2];
  logic signed [ACC_W-1:0]  acc_r [2];
  logic [TRUST_W-1:0]       tsh_r;
  logic [15:0] res_r [3];
  logic res_v_r;
  logic [47:0] out_r;
  logic out_v_r;

  logic in_acc, out_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_v_r & out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MUL;
      S_MUL:  if (cnt_r == CNT_W'(GAIN_W-1)) state_nxt = S_COR;
      S_COR:  if (cnt_r == CNT_W'(STEPS-1)) state_nxt = S_BLD;
      S_BLD:  if (cnt_r == CNT_W'(TRUST_W-1)) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_DONE;
      S_DONE: if (!res_v_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  function automatic logic signed [STATE_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] mx, mn;
    mx = ACC_W'((1 << (STATE_W-1)) - 1);
    mn = -ACC_W'(1 << (STATE_W-1));
    if (v > mx) return mx[STATE_W-1:0];
    if (v < mn) return mn[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

  function automatic logic [15:0] to_out(input logic signed [STATE_W-1:0] s);
    logic [STATE_W-1:0] m;
    logic [STATE_W-9:0] q;
    m = s[STATE_W-1] ? STATE_W'(-s) : STATE_W'(s);
    q = m[STATE_W-1:8];
    if (!s[STATE_W-1]) return (q > 32767) ? 16'h7FFF : q[15:0];
    if (q > 32768) return 16'h8000;
    return 16'(-q);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < 3; k++) est_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) cnt_r <= '0;
      else cnt_r <= cnt_r + 1'b1;
      if (res_v_r && (!out_v_r || out_acc)) begin
        out_r   <= {res_r[2], res_r[1], res_r[0]};
        out_v_r <= 1'b1;
        res_v_r <= 1'b0;
      end else if (out_acc) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          for (int k = 0; k < 3; k++) begin
            gneg_r[k] <= gin[k][GYRO_WIDTH-1];
            gmag_r[k] <= gin[k][GYRO_WIDTH-1] ? GMAG_W'(-gin[k]) : GMAG_W'(gin[k]);
            prod_r[k] <= '0;
          end
          gsh_r <= gain_r;
          for (int k = 0; k < 2; k++) begin
            aneg_r[k] <= ain[k][ACCEL_WIDTH-1];
            azero_r[k] <= (ain[k] == '0);
            cy_r[k] <= CX_W'({(ain[k][ACCEL_WIDTH-1] ? AMAG_W'(-ain[k])
                                : AMAG_W'(ain[k])), 8'd0});
            cx_r[k] <= CX_W'({(ain[2][ACCEL_WIDTH-1] ? AMAG_W'(-ain[2])
                                : AMAG_W'(ain[2])), 8'd0});
            cang_r[k] <= '0;
          end
        end
        S_MUL: begin
          // MSB-first shift-add: one gain bit per cycle.
          for (int k = 0; k < 3; k++)
            prod_r[k] <= {prod_r[k][PROD_W-2:0], 1'b0} +
                         (gsh_r[GAIN_W-1] ? PROD_W'(gmag_r[k]) : '0);
          gsh_r <= {gsh_r[GAIN_W-2:0], 1'b0};
          if (cnt_r == '0)
            for (int k = 0; k < 3; k++) gzero_r[k] <= (gmag_r[k] < GMAG_W'(db_r));
        end
        S_COR: begin
          for (int k = 0; k < 2; k++) begin
            if (cy_r[k] > 0) begin
              cx_r[k] <= cx_r[k] + (cy_r[k] >>> cnt_r);
              cy_r[k] <= cy_r[k] - (cx_r[k] >>> cnt_r);
              cang_r[k] <= cang_r[k] + (ANG_W+2)'(atan_q8(cnt_r));
            end else begin
              cx_r[k] <= cx_r[k] - (cy_r[k] >>> cnt_r);
              cy_r[k] <= cy_r[k] + (cx_r[k] >>> cnt_r);
              cang_r[k] <= cang_r[k] - (ANG_W+2)'(atan_q8(cnt_r));
            end
          end
          if (cnt_r == CNT_W'(STEPS-1)) begin
            // Trust above one is clamped to one for the blend.
            tsh_r <= (trust_r > TRUST_W'(32768)) ? TRUST_W'(32768) : trust_r;
          end
        end
        S_BLD: begin
          if (cnt_r == '0) begin
            for (int k = 0; k < 2; k++) begin
              logic signed [STEP_W-1:0] st;
              logic signed [SUM_W-1:0] tl;
              st = gzero_r[k] ? '0 : STEP_W'((prod_r[k] + PROD_W'(128)) >> 8);
              if (gneg_r[k]) st = -st;
              tl = azero_r[k] ? '0 : SUM_W'(cang_r[k]);
              if (aneg_r[k]) tl = -tl;
              sumg_r[k] <= SUM_W'(est_r[k]) + SUM_W'(st);
              tilt_r[k] <= tl;
              // acc = 32768*tilt + 16384 + trust*(sum - tilt), built bitwise.
              acc_r[k] <= (ACC_W'(tl) <<< 15) + ACC_W'(16384);
            end
          end else begin
            for (int k = 0; k < 2; k++)
              if (tsh_r[TRUST_W - 1 - (cnt_r - 1'b1)])
                acc_r[k] <= acc_r[k] +
                  (ACC_W'(sumg_r[k] - tilt_r[k]) <<< (TRUST_W - 1 - (cnt_r - 1'b1)));
          end
        end
        S_UPD: begin
          for (int k = 0; k < 2; k++) begin
            logic signed [ACC_W-1:0] a;
            a = acc_r[k];
            if (tsh_r[0]) a = a + ACC_W'(sumg_r[k] - tilt_r[k]);
            est_r[k] <= sat_st(a >>> 15);
            res_r[k] <= to_out(sat_st(a >>> 15));
          end
          begin
            logic signed [STEP_W-1:0] sz;
            logic signed [ACC_W-1:0] y;
            sz = gzero_r[2] ? '0 : STEP_W'((prod_r[2] + PROD_W'(128)) >> 8);
            if (gneg_r[2]) sz = -sz;
            y = ACC_W'(est_r[2]) + ACC_W'(sz);
            est_r[2] <= sat_st(y);
            res_r[2] <= to_out(sat_st(y));
          end
          res_v_r <= 1'b1;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  `TCF_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, state_r == S_IDLE && !res_v_r || state_r == S_IDLE, "ready outside idle")
  `TCF_ASSERT_NXT(a_out_hold, clk, rst_n, out_v_r && !out_tready, out_v_r && $stable(out_r), "result dropped while stalled")
  `TCF_ASSERT_NXT(a_upd_res, clk, rst_n, state_r == S_UPD, res_v_r, "result not staged after update")
endmodule
